// ----- hdl/dvr_pkg.sv -----
package dvr_pkg;

  // Fixed sizes of the routing table and of the cost fields.
  localparam int unsigned MAXN   = 4;
  localparam int unsigned COST_W = 10;
  localparam int unsigned NODE_W = 2;

  // Defaults for the top-level parameters.
  localparam int unsigned NODE_COUNT_DEF    = 4;
  localparam int unsigned COST_INFINITY_DEF = 999;

  typedef logic [COST_W-1:0] cost_t;
  typedef logic [NODE_W-1:0] node_t;

  // Event kinds carried in the func field.
  localparam logic [1:0] FUNC_INIT   = 2'd0;
  localparam logic [1:0] FUNC_VECTOR = 2'd1;
  localparam logic [1:0] FUNC_LINK   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_LINK_ONE   = 2'd0;
  localparam logic [1:0] REG_LINK_TWO   = 2'd1;
  localparam logic [1:0] REG_LINK_THREE = 2'd2;

  // Link costs after reset, node 0 itself first.
  localparam cost_t LINK_RST [MAXN] = '{10'd0, 10'd1, 10'd3, 10'd7};

  // Command shared by all lanes for one table update.
  typedef struct packed {
    logic [1:0] func;
    node_t      node;
    cost_t      new_cost;
    cost_t      link_cost;
  } lane_cmd_t;

  // Control from the sequencer to the merging stage.
  typedef struct packed {
    logic cmp;
    logic force_adv;
  } merge_ctl_t;

  // Status back from the merging stage.
  typedef struct packed {
    logic emit;
    logic busy;
    logic done;
  } merge_stat_t;

  // Clamp an 11-bit sum to the infinite cost.
  function automatic cost_t sat_cost(input logic [COST_W:0] v, input cost_t inf);
    return (v >= {1'b0, inf}) ? inf : v[COST_W-1:0];
  endfunction

  // Advertised minimum held after reset.
  function automatic cost_t reset_min(input int unsigned d, input int unsigned nc,
                                      input cost_t inf);
    cost_t r;
    r = '0;
    if (d < nc) begin
      r = sat_cost({1'b0, LINK_RST[d[NODE_W-1:0]]}, inf);
    end
    return r;
  endfunction

endpackage

// ----- hdl/dvr_if.sv -----
// Channel carrying routing events into the block.
interface dvr_in_if;
  import dvr_pkg::*;

  logic  valid;
  logic  ready;
  logic [1:0] func;
  node_t neighbor_id;
  cost_t cost_to_zero;
  cost_t cost_to_one;
  cost_t cost_to_two;
  cost_t cost_to_three;
  cost_t new_link_cost;

  modport source (
    output valid, func, neighbor_id, cost_to_zero, cost_to_one, cost_to_two,
           cost_to_three, new_link_cost,
    input  ready
  );
  modport sink (
    input  valid, func, neighbor_id, cost_to_zero, cost_to_one, cost_to_two,
           cost_to_three, new_link_cost,
    output ready
  );
endinterface

// Channel carrying advertisement packets out of the block.
interface dvr_out_if;
  import dvr_pkg::*;

  logic  valid;
  logic  ready;
  node_t dest_node;
  cost_t min_zero;
  cost_t min_one;
  cost_t min_two;
  cost_t min_three;
  logic  last;

  modport source (
    output valid, dest_node, min_zero, min_one, min_two, min_three, last,
    input  ready
  );
  modport sink (
    input  valid, dest_node, min_zero, min_one, min_two, min_three, last,
    output ready
  );
endinterface

// ----- hdl/distance_vector_route_update.sv -----
// An event is taken into the table at the edge that accepts it; the row
// minimums are compared in the next cycle and the first packet is shown the
// cycle after that. The next event is taken only when the last is through:
// after its last packet is taken when the vector changes (three packets from
// one output register), after the comparison otherwise, or at once if ignored.
// Reset clears the sequencer and loads the table and vector from reset costs.
module distance_vector_route_update #(
  parameter int unsigned NODE_COUNT    = dvr_pkg::NODE_COUNT_DEF,
  parameter int unsigned COST_INFINITY = dvr_pkg::COST_INFINITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dvr_in_if.sink      item_i,
  dvr_out_if.source   result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dvr_pkg::*;

  localparam cost_t      INF     = cost_t'(COST_INFINITY);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  logic [1:0]  state_q, state_d;
  logic        force_q;
  logic        accept;
  logic        evt_ok;
  cost_t       link_reg [3];
  cost_t       init_cost [MAXN];
  cost_t       vec [MAXN];
  cost_t       diag [MAXN];
  cost_t       mins [MAXN];
  lane_cmd_t   cmd;
  merge_ctl_t  mctl;
  merge_stat_t mstat;

  // Configuration registers.
  dvr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .link_o  (link_reg)
  );

  // Link costs as loaded by an init event.
  assign init_cost[0] = '0;
  assign init_cost[1] = sat_cost({1'b0, link_reg[0]}, INF);
  assign init_cost[2] = sat_cost({1'b0, link_reg[1]}, INF);
  assign init_cost[3] = sat_cost({1'b0, link_reg[2]}, INF);

  assign vec[0] = item_i.cost_to_zero;
  assign vec[1] = item_i.cost_to_one;
  assign vec[2] = item_i.cost_to_two;
  assign vec[3] = item_i.cost_to_three;

  // Only events that touch the table start a comparison.
  assign accept = item_i.valid & item_i.ready;
  assign evt_ok = (item_i.func == FUNC_INIT) ||
                  (((item_i.func == FUNC_VECTOR) || (item_i.func == FUNC_LINK)) &&
                   (item_i.neighbor_id != '0) &&
                   ({30'd0, item_i.neighbor_id} < NODE_COUNT));

  // The neighbour's current link cost comes from its own lane's diagonal.
  assign cmd.func      = item_i.func;
  assign cmd.node      = item_i.neighbor_id;
  assign cmd.new_cost  = item_i.new_link_cost;
  assign cmd.link_cost = diag[item_i.neighbor_id];

  for (genvar g = 0; g < MAXN; g++) begin : g_lane
    dvr_lane #(
      .LANE          (g),
      .NODE_COUNT    (NODE_COUNT),
      .COST_INFINITY (COST_INFINITY)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .upd_i       (accept & evt_ok),
      .cmd_i       (cmd),
      .vec_i       (vec[g]),
      .init_cost_i (init_cost[g]),
      .diag_o      (diag[g]),
      .min_o       (mins[g])
    );
  end

  assign mctl.cmp       = (state_q == ST_CMP);
  assign mctl.force_adv = force_q;

  dvr_merge #(
    .NODE_COUNT    (NODE_COUNT),
    .COST_INFINITY (COST_INFINITY)
  ) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mctl),
    .mins_i (mins),
    .stat_o (mstat),
    .out_o  (result_o)
  );

  // Event sequencer: one item in flight at a time.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept && evt_ok) state_d = ST_CMP;
      ST_CMP:  state_d = mstat.emit ? ST_SEND : ST_IDLE;
      ST_SEND: if (mstat.done || !mstat.busy) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      force_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        force_q <= (item_i.func == FUNC_INIT);
      end
    end
  end

  assign item_i.ready = (state_q == ST_IDLE);

endmodule

// ----- hdl/dvr_cfg.sv -----
module dvr_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output dvr_pkg::cost_t      link_o [3]
);
  import dvr_pkg::*;

  cost_t      link_q [3];
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  // Register writes complete in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q[0] <= LINK_RST[1];
      link_q[1] <= LINK_RST[2];
      link_q[2] <= LINK_RST[3];
    end else if (wr_en) begin
      case (reg_idx)
        REG_LINK_ONE:   link_q[0] <= pwdata[COST_W-1:0];
        REG_LINK_TWO:   link_q[1] <= pwdata[COST_W-1:0];
        REG_LINK_THREE: link_q[2] <= pwdata[COST_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back; unused addresses read as zero.
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_LINK_ONE:   prdata = {22'd0, link_q[0]};
      REG_LINK_TWO:   prdata = {22'd0, link_q[1]};
      REG_LINK_THREE: prdata = {22'd0, link_q[2]};
      default:        prdata = '0;
    endcase
  end

  assign link_o = link_q;

endmodule

// ----- hdl/dvr_lane.sv -----
module dvr_lane #(
  parameter int unsigned LANE          = 0,
  parameter int unsigned NODE_COUNT    = dvr_pkg::NODE_COUNT_DEF,
  parameter int unsigned COST_INFINITY = dvr_pkg::COST_INFINITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               upd_i,
  input  dvr_pkg::lane_cmd_t cmd_i,
  input  dvr_pkg::cost_t     vec_i,
  input  dvr_pkg::cost_t     init_cost_i,
  output dvr_pkg::cost_t     diag_o,
  output dvr_pkg::cost_t     min_o
);
  import dvr_pkg::*;

  localparam cost_t INF    = cost_t'(COST_INFINITY);
  localparam node_t LIDX   = node_t'(LANE);
  localparam bit    ACTIVE = (LANE < NODE_COUNT);

  // One row of the cost table: this destination, by next hop.
  cost_t             row_q [MAXN];
  cost_t             row_d [MAXN];
  cost_t             entry;
  cost_t             new_sat;
  cost_t             diff;
  logic [COST_W:0]   sum_vec;
  logic [COST_W:0]   sum_lnk;
  cost_t             best;

  assign entry   = row_q[cmd_i.node];
  assign new_sat = sat_cost({1'b0, cmd_i.new_cost}, INF);
  assign diff    = (entry > cmd_i.link_cost) ? entry - cmd_i.link_cost : '0;
  assign sum_vec = {1'b0, cmd_i.link_cost} + {1'b0, vec_i};
  assign sum_lnk = {1'b0, new_sat} + {1'b0, diff};

  // New row contents for the current event.
  always_comb begin
    row_d = row_q;
    case (cmd_i.func)
      FUNC_INIT: begin
        for (int unsigned v = 0; v < MAXN; v++) begin
          row_d[v[NODE_W-1:0]] = (v == LANE) ? init_cost_i : INF;
        end
      end
      FUNC_VECTOR: begin
        if (ACTIVE) begin
          row_d[cmd_i.node] = sat_cost(sum_vec, INF);
        end
      end
      FUNC_LINK: begin
        if (ACTIVE) begin
          if (cmd_i.node == LIDX) begin
            row_d[cmd_i.node] = new_sat;
          end else if (entry >= INF || cmd_i.link_cost >= INF) begin
            row_d[cmd_i.node] = INF;
          end else begin
            row_d[cmd_i.node] = sat_cost(sum_lnk, INF);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned v = 0; v < MAXN; v++) begin
        row_q[v[NODE_W-1:0]] <= (v == LANE) ? sat_cost({1'b0, LINK_RST[LIDX]}, INF) : INF;
      end
    end else if (upd_i) begin
      row_q <= row_d;
    end
  end

  // Row minimum over the nodes in use.
  always_comb begin
    best = INF;
    for (int unsigned v = 0; v < NODE_COUNT; v++) begin
      if (row_q[v[NODE_W-1:0]] < best) begin
        best = row_q[v[NODE_W-1:0]];
      end
    end
  end

  assign min_o  = ACTIVE ? best : '0;
  assign diag_o = row_q[LIDX];

endmodule

// ----- hdl/dvr_merge.sv -----
module dvr_merge #(
  parameter int unsigned NODE_COUNT    = dvr_pkg::NODE_COUNT_DEF,
  parameter int unsigned COST_INFINITY = dvr_pkg::COST_INFINITY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dvr_pkg::merge_ctl_t  ctl_i,
  input  dvr_pkg::cost_t       mins_i [dvr_pkg::MAXN],
  output dvr_pkg::merge_stat_t stat_o,
  dvr_out_if.source            out_o
);
  import dvr_pkg::*;

  localparam cost_t INF       = cost_t'(COST_INFINITY);
  localparam node_t LAST_DEST = node_t'(NODE_COUNT - 1);

  cost_t adv_q [MAXN];
  logic  valid_q;
  node_t dest_q;
  logic  last_q;
  logic  changed;
  logic  emit;
  logic  take;
  node_t dest_nx;

  // Compare the lane minimums against the vector last advertised.
  always_comb begin
    changed = 1'b0;
    for (int unsigned d = 0; d < MAXN; d++) begin
      if (mins_i[d[NODE_W-1:0]] != adv_q[d[NODE_W-1:0]]) begin
        changed = 1'b1;
      end
    end
  end

  assign emit    = ctl_i.cmp & (ctl_i.force_adv | changed);
  assign take    = valid_q & out_o.ready;
  assign dest_nx = dest_q + node_t'(1);

  // Advertised vector, loaded when a burst starts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned d = 0; d < MAXN; d++) begin
        adv_q[d[NODE_W-1:0]] <= reset_min(d, NODE_COUNT, INF);
      end
    end else if (emit) begin
      adv_q <= mins_i;
    end
  end

  // Packet sequencer: one item per neighbour, in ascending order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (emit) begin
      valid_q <= 1'b1;
    end else if (take && last_q) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      dest_q <= node_t'(1);
      last_q <= (LAST_DEST == node_t'(1));
    end else if (take && !last_q) begin
      dest_q <= dest_nx;
      last_q <= (dest_nx == LAST_DEST);
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.dest_node = dest_q;
  assign out_o.min_zero  = adv_q[0];
  assign out_o.min_one   = adv_q[1];
  assign out_o.min_two   = adv_q[2];
  assign out_o.min_three = adv_q[3];
  assign out_o.last      = last_q;

  assign stat_o.emit = emit;
  assign stat_o.busy = valid_q;
  assign stat_o.done = take & last_q;

endmodule
